FILE: hdl/rbd_pkg.sv
// ----------------------------------------------------------------------------
// Ring buffer deque package
// Opcodes, status codes, cell control bundle and default sizes.
// ----------------------------------------------------------------------------
package rbd_pkg;

  localparam int unsigned RbdDepthDef     = 32;
  localparam int unsigned RbdDataWidthDef = 32;

  localparam int unsigned OpWidth     = 3;
  localparam int unsigned ValueWidth  = 32;
  localparam int unsigned StatusWidth = 2;
  localparam int unsigned OccWidth    = 6;

  localparam int unsigned InFieldsW  = OpWidth + ValueWidth;
  localparam int unsigned InTdataW   = ((InFieldsW + 7) / 8) * 8;
  localparam int unsigned OutFieldsW = ValueWidth + StatusWidth + OccWidth + 1;
  localparam int unsigned OutTdataW  = ((OutFieldsW + 7) / 8) * 8;

  typedef enum logic [OpWidth-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_PEEK_FRONT = 3'd4,
    OP_PEEK_BACK  = 3'd5
  } rbd_op_e;

  typedef enum logic [StatusWidth-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } rbd_status_e;

  typedef struct packed {
    logic add_front;
    logic add_back;
    logic take_front;
    logic take_back;
  } rbd_ctl_t;

endpackage

FILE: hdl/ring_buffer_deque_top.sv
// ----------------------------------------------------------------------------
// Ring buffer deque top level
// Double-ended queue over a row of shifting cells with a registered result.
// ----------------------------------------------------------------------------
// The result of a transaction is registered and presented in the cycle after acceptance.
// Throughput: one transaction per cycle unless m_axis_tready stalls the result;
// the front and back words sit in cell 0 of the two cell chains, so no operation walks them.
// Reset clears the occupancy count and the result valid; cell storage is not
// cleared and is read only once written.
module ring_buffer_deque_top
  import rbd_pkg::*;
#(
  parameter int unsigned DEPTH      = RbdDepthDef,
  parameter int unsigned DATA_WIDTH = RbdDataWidthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [2:0] opcode, [34:3] push_value, rest zero
  input  logic [InTdataW-1:0]  s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [31:0] read_value, [33:32] status, [39:34] occupancy, [40] empty_flag, rest zero
  output logic [OutTdataW-1:0] m_axis_tdata
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0]       count_q, count_d;
  logic                  out_valid_q;
  logic [OutFieldsW-1:0] out_q, out_d;

  rbd_op_e               op;
  logic [ValueWidth-1:0] push_value;
  logic [DATA_WIDTH-1:0] wdata;
  logic                  in_acc, full, empty;
  rbd_ctl_t              ctl;
  rbd_status_e           status;
  logic [DATA_WIDTH-1:0] rd_word;
  logic                  rd_en;
  logic [ValueWidth-1:0] read_value;
  logic [63:0]           rd_ext, wr_ext;

  logic [DATA_WIDTH-1:0] f_w [DEPTH];
  logic [DATA_WIDTH-1:0] b_w [DEPTH];

  assign op         = rbd_op_e'(s_axis_tdata[OpWidth-1:0]);
  assign push_value = s_axis_tdata[OpWidth +: ValueWidth];
  assign wr_ext     = 64'($signed(push_value));
  assign wdata      = wr_ext[DATA_WIDTH-1:0];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign full          = (count_q == CntW'(DEPTH));
  assign empty         = (count_q == '0);

  always_comb begin
    ctl     = '0;
    status  = ST_OK;
    rd_en   = 1'b0;
    rd_word = f_w[0];
    count_d = count_q;
    unique case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          ctl.add_front = in_acc && (op == OP_PUSH_FRONT);
          ctl.add_back  = in_acc && (op == OP_PUSH_BACK);
          count_d       = count_q + 1'b1;
        end
      end
      OP_POP_FRONT, OP_PEEK_FRONT: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          rd_en          = 1'b1;
          ctl.take_front = in_acc && (op == OP_POP_FRONT);
          if (op == OP_POP_FRONT) begin
            count_d = count_q - 1'b1;
          end
        end
      end
      OP_POP_BACK, OP_PEEK_BACK: begin
        rd_word = b_w[0];
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          rd_en         = 1'b1;
          ctl.take_back = in_acc && (op == OP_POP_BACK);
          if (op == OP_POP_BACK) begin
            count_d = count_q - 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign rd_ext     = 64'($signed(rd_word));
  assign read_value = rd_en ? rd_ext[ValueWidth-1:0] : '0;
  assign out_d      = {(count_d == '0), OccWidth'(count_d), status, read_value};

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] f_prev, f_next, b_prev, b_next;
    assign f_prev = (i == 0) ? wdata : f_w[(i == 0) ? 0 : i - 1];
    assign b_prev = (i == 0) ? wdata : b_w[(i == 0) ? 0 : i - 1];
    assign f_next = f_w[(i == DEPTH - 1) ? i : i + 1];
    assign b_next = b_w[(i == DEPTH - 1) ? i : i + 1];

    rbd_cell #(
      .DATA_WIDTH(DATA_WIDTH),
      .CNT_W     (CntW),
      .INDEX     (i)
    ) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .count_i (count_q),
      .wdata_i (wdata),
      .f_prev_i(f_prev),
      .f_next_i(f_next),
      .b_prev_i(b_prev),
      .b_next_i(b_next),
      .f_o     (f_w[i]),
      .b_o     (b_w[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutTdataW'(out_q);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("occupancy beyond depth");

  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && full && (op == OP_PUSH_FRONT || op == OP_PUSH_BACK)) |=> $stable(count_q))
    else $error("refused push changed occupancy");

  a_pop_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !empty && (op == OP_POP_FRONT || op == OP_POP_BACK))
      |=> (count_q == $past(count_q) - 1'b1))
    else $error("pop did not reduce occupancy");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> m_axis_tvalid)
    else $error("accepted transaction produced no result");

endmodule

FILE: hdl/rbd_cell.sv
// ----------------------------------------------------------------------------
// Ring buffer deque cell
// One position of the deque held twice: front-ordered and back-ordered copy.
// ----------------------------------------------------------------------------
module rbd_cell
  import rbd_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = RbdDataWidthDef,
  parameter int unsigned CNT_W      = 6,
  parameter int unsigned INDEX      = 0
) (
  input  logic                  clk_i,
  input  rbd_ctl_t              ctl_i,
  input  logic [CNT_W-1:0]      count_i,
  input  logic [DATA_WIDTH-1:0] wdata_i,
  input  logic [DATA_WIDTH-1:0] f_prev_i,
  input  logic [DATA_WIDTH-1:0] f_next_i,
  input  logic [DATA_WIDTH-1:0] b_prev_i,
  input  logic [DATA_WIDTH-1:0] b_next_i,
  output logic [DATA_WIDTH-1:0] f_o,
  output logic [DATA_WIDTH-1:0] b_o
);

  logic [DATA_WIDTH-1:0] f_q, f_d;
  logic [DATA_WIDTH-1:0] b_q, b_d;
  logic                  at_count;

  assign at_count = (count_i == CNT_W'(INDEX));

  always_comb begin
    f_d = f_q;
    b_d = b_q;
    if (ctl_i.add_front) begin
      f_d = f_prev_i;
      if (at_count) begin
        b_d = wdata_i;
      end
    end else if (ctl_i.add_back) begin
      b_d = b_prev_i;
      if (at_count) begin
        f_d = wdata_i;
      end
    end else if (ctl_i.take_front) begin
      f_d = f_next_i;
    end else if (ctl_i.take_back) begin
      b_d = b_next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    f_q <= f_d;
    b_q <= b_d;
  end

  assign f_o = f_q;
  assign b_o = b_q;

endmodule
